// File: rtl/acmr_pkg.sv
// ----------------------------------------------------------------------------
// acmr_pkg: shared types and constants
// Field widths, table depths, function codes and the controller/datapath
// command and status structs of the match reporter.
// ----------------------------------------------------------------------------
package acmr_pkg;

   localparam int STATE_W   = 10;
   localparam int SYM_W     = 7;
   localparam int SLOT_W    = 12;
   localparam int PAT_W     = 8;
   localparam int LEN_W     = 16;
   localparam int CNT_W     = 5;
   localparam int TOTAL_W   = 20;
   localparam int NSTATES   = 1024;
   localparam int NSLOTS    = 4096;
   localparam int NPATS     = 256;
   localparam int NSYMS     = 128;
   localparam logic [CNT_W-1:0] MAX_OUTS = 5'd16;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

   localparam logic [2:0] FUNC_TRANS = 3'd0;
   localparam logic [2:0] FUNC_INFO  = 3'd1;
   localparam logic [2:0] FUNC_LIST  = 3'd2;
   localparam logic [2:0] FUNC_LEN   = 3'd3;
   localparam logic [2:0] FUNC_SCAN  = 3'd4;

   localparam logic KIND_REPORT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic load;      // perform a table write for the held word
      logic step;      // latch next state, info, update position
      logic emit_rep;  // load output register with a report
      logic emit_sum;  // load output register with a summary
      logic rep_last;
      logic sum_bad;
      logic add_total; // add match count to total
      logic next_rep;  // advance report index
      logic new_str;
      logic set_stop;
   } acmr_cmd_type;

   typedef struct packed {
      logic out_busy;    // output register full and not leaving
      logic stopped;
      logic total_zero;
      logic [CNT_W-1:0] count;
      logic rep_done;    // report index at last entry
   } acmr_stat_type;

endpackage

// File: rtl/aho_corasick_match_reporter_unit.sv
// ----------------------------------------------------------------------------
// aho_corasick_match_reporter_unit: DFA scanner with match reports
// Top level: CSR port, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_ words load the automaton tables (no result) or carry one scan
//   byte. rsp_ words are match reports and one summary per string. csr_
//   writes set stop_at_first (0x0) and report_enable (0x4). A scan byte
//   passes through the transition and state info reads, then a list read,
//   a length read and an emit per reported pattern, and the summary when
//   the string ends or stops at its first match; a byte outside the
//   alphabet goes straight to the summary. The dependent table reads set
//   these steps. req_stall is high while a word is in flight.
//   Reset returns to the root state with position and total zero; the
//   tables hold whatever was last written. A stalled rsp_ word holds, and
//   the sequencer and the input wait on it before the next result.
// ----------------------------------------------------------------------------
module aho_corasick_match_reporter_unit
   import acmr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [STATE_W-1:0] req_table_state,
   input  logic [SYM_W-1:0]   req_table_symbol,
   input  logic [STATE_W-1:0] req_next_state,
   input  logic [CNT_W-1:0]   req_output_count,
   input  logic [SLOT_W-1:0]  req_out_base,
   input  logic [SLOT_W-1:0]  req_list_index,
   input  logic [PAT_W-1:0]   req_entry_pattern,
   input  logic [LEN_W-1:0]   req_pattern_length,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic [PAT_W-1:0]   rsp_match_pattern,
   output logic [LEN_W-1:0]   rsp_match_start,
   output logic [TOTAL_W-1:0] rsp_match_count,
   output logic               rsp_bad_byte,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic [2:0] ADDR_STOP = 3'h0;
   localparam logic [2:0] ADDR_REPORT = 3'h4;

   logic stop_ff, report_ff;
   acmr_cmd_type cmd;
   acmr_stat_type stat;
   logic ph_read, ph_list, ph_len;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff <= 1'b0;
         report_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == ADDR_STOP) stop_ff <= csr_pwdata[0];
         if (csr_paddr == ADDR_REPORT) report_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_STOP:   csr_prdata = {31'd0, stop_ff};
         ADDR_REPORT: csr_prdata = {31'd0, report_ff};
         default:     csr_prdata = '0;
      endcase
   end

   acmr_control u_ctl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .func(req_func), .data_byte(req_data_byte), .last_byte(req_last_byte),
      .stop_at_first(stop_ff), .report_enable(report_ff),
      .stat(stat), .cmd(cmd),
      .phase_read(ph_read), .phase_list(ph_list), .phase_len(ph_len)
   );

   acmr_datapath u_dp (
      .clock(clock), .reset(reset), .hold_in(req_valid),
      .func(req_func), .table_state(req_table_state),
      .table_symbol(req_table_symbol), .next_state(req_next_state),
      .output_count(req_output_count), .out_base(req_out_base),
      .list_index(req_list_index), .entry_pattern(req_entry_pattern),
      .pattern_length(req_pattern_length), .data_byte(req_data_byte),
      .cmd(cmd), .phase_read(ph_read), .phase_list(ph_list), .phase_len(ph_len),
      .stat(stat), .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind), .rsp_match_pattern(rsp_match_pattern),
      .rsp_match_start(rsp_match_start), .rsp_match_count(rsp_match_count),
      .rsp_bad_byte(rsp_bad_byte), .rsp_last(rsp_last)
   );

endmodule

// File: rtl/acmr_datapath.sv
// ----------------------------------------------------------------------------
// acmr_datapath: tables, scan state and output register
// Holds the automaton memories, current state, position, match total, and
// the result register presented on the rsp_ channel.
// ----------------------------------------------------------------------------
module acmr_datapath
   import acmr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                hold_in,
   input  logic [2:0]          func,
   input  logic [STATE_W-1:0]  table_state,
   input  logic [SYM_W-1:0]    table_symbol,
   input  logic [STATE_W-1:0]  next_state,
   input  logic [CNT_W-1:0]    output_count,
   input  logic [SLOT_W-1:0]   out_base,
   input  logic [SLOT_W-1:0]   list_index,
   input  logic [PAT_W-1:0]    entry_pattern,
   input  logic [LEN_W-1:0]    pattern_length,
   input  logic [7:0]          data_byte,
   input  acmr_cmd_type        cmd,
   input  logic                phase_read,
   input  logic                phase_list,
   input  logic                phase_len,
   output acmr_stat_type       stat,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_kind,
   output logic [PAT_W-1:0]    rsp_match_pattern,
   output logic [LEN_W-1:0]    rsp_match_start,
   output logic [TOTAL_W-1:0]  rsp_match_count,
   output logic                rsp_bad_byte,
   output logic                rsp_last
);

   logic [STATE_W-1:0] trans_mem [NSTATES*NSYMS];
   logic [CNT_W+SLOT_W-1:0] info_mem [NSTATES];
   logic [PAT_W-1:0] list_mem [NSLOTS];
   logic [LEN_W-1:0] len_mem [NPATS];

   logic [STATE_W-1:0] state_ff, state_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W:0] total_sum;
   logic [STATE_W-1:0] trans_rd_ff;
   logic [CNT_W+SLOT_W-1:0] info_rd_ff;
   logic [PAT_W-1:0] list_rd_ff;
   logic [LEN_W-1:0] len_rd_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [LEN_W-1:0] rpos_ff;
   logic [CNT_W-1:0] cnt_w;
   logic [SLOT_W-1:0] slot;
   logic valid_ff;

   assign cnt_w = (output_count > MAX_OUTS) ? MAX_OUTS : output_count;
   assign slot = info_rd_ff[SLOT_W-1:0] + SLOT_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         case (func)
            FUNC_TRANS: trans_mem[{table_state, table_symbol}] <= next_state;
            FUNC_INFO:  info_mem[table_state] <= {cnt_w, out_base};
            FUNC_LIST:  list_mem[list_index] <= entry_pattern;
            FUNC_LEN:   len_mem[entry_pattern] <= pattern_length;
            default: ;
         endcase
      end
      if (phase_read) trans_rd_ff <= trans_mem[{state_ff, data_byte[SYM_W-1:0]}];
      if (cmd.step) info_rd_ff <= info_mem[trans_rd_ff];
      if (phase_list) list_rd_ff <= list_mem[slot];
      if (phase_len) len_rd_ff <= len_mem[list_rd_ff];
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      total_in = total_ff;
      total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(info_rd_ff[CNT_W+SLOT_W-1:SLOT_W]);
      if (cmd.step) begin
         state_in = trans_rd_ff;
         pos_in = pos_ff + 1'b1;
      end
      if (cmd.add_total)
         total_in = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      if (cmd.new_str) begin
         state_in = '0;
         pos_in = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         pos_ff <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         total_ff <= total_in;
         if (cmd.step) idx_ff <= '0;
         else if (cmd.next_rep) idx_ff <= idx_ff + 1'b1;
         if (cmd.emit_rep || cmd.emit_sum) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) rpos_ff <= pos_ff;
      if (cmd.emit_rep) begin
         rsp_kind <= KIND_REPORT;
         rsp_match_pattern <= list_rd_ff;
         rsp_match_start <= rpos_ff + 1'b1 - len_rd_ff;
         rsp_match_count <= '0;
         rsp_bad_byte <= 1'b0;
         rsp_last <= cmd.rep_last;
      end else if (cmd.emit_sum) begin
         rsp_kind <= KIND_SUMMARY;
         rsp_match_pattern <= '0;
         rsp_match_start <= '0;
         rsp_match_count <= total_ff;
         rsp_bad_byte <= cmd.sum_bad;
         rsp_last <= 1'b1;
      end
   end

   assign rsp_valid = valid_ff;
   assign stat.out_busy = valid_ff && rsp_stall;
   assign stat.stopped = 1'b0;
   assign stat.total_zero = (total_ff == '0);
   assign stat.count = info_rd_ff[CNT_W+SLOT_W-1:SLOT_W];
   assign stat.rep_done = (idx_ff + 1'b1 == stat.count);

   // hold_in carries req_valid; no datapath action of its own
   logic unused_hold;
   assign unused_hold = hold_in;

endmodule

// File: rtl/acmr_control.sv
// ----------------------------------------------------------------------------
// acmr_control: scan sequencer
// Accepts words, sequences table reads, report emission and the summary.
// ----------------------------------------------------------------------------
module acmr_control
   import acmr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [2:0]    func,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   input  logic          stop_at_first,
   input  logic          report_enable,
   input  acmr_stat_type stat,
   output acmr_cmd_type  cmd,
   output logic          phase_read,
   output logic          phase_list,
   output logic          phase_len
);

   typedef enum logic [2:0] {
      S_IDLE, S_TRANS, S_INFO, S_LIST, S_LEN, S_EMIT, S_SUM
   } state_type;

   state_type state_ff;
   logic last_ff, stop_ff, ended_ff, bad_ff;
   logic accept;

   assign req_stall = (state_ff != S_IDLE) || stat.out_busy;
   assign accept = req_valid && !req_stall;
   assign phase_read = accept && func == FUNC_SCAN;
   assign phase_list = state_ff == S_LIST;
   assign phase_len = state_ff == S_LEN;

   always_comb begin
      cmd = '0;
      cmd.load = accept && func != FUNC_SCAN;
      if (accept && func == FUNC_SCAN && stop_ff && last_byte) cmd.new_str = 1'b1;
      cmd.step = state_ff == S_TRANS;
      if (state_ff == S_INFO) cmd.add_total = 1'b1;
      if (state_ff == S_EMIT && !stat.out_busy) begin
         cmd.emit_rep = 1'b1;
         cmd.rep_last = stat.rep_done && !ended_ff;
         cmd.next_rep = 1'b1;
      end
      if (state_ff == S_SUM && !stat.out_busy) begin
         cmd.emit_sum = 1'b1;
         cmd.sum_bad = bad_ff;
         cmd.new_str = last_ff;
         cmd.set_stop = !last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stop_ff <= 1'b0;
         last_ff <= 1'b0;
         ended_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (accept && func == FUNC_SCAN) begin
               last_ff <= last_byte;
               if (stop_ff) begin
                  if (last_byte) stop_ff <= 1'b0;
               end else if (data_byte[7]) begin
                  bad_ff <= 1'b1;
                  state_ff <= S_SUM;
               end else begin
                  bad_ff <= 1'b0;
                  state_ff <= S_TRANS;
               end
            end
            S_TRANS: state_ff <= S_INFO;
            S_INFO: begin
               ended_ff <= last_ff || (stop_at_first && stat.count != '0 && stat.total_zero);
               if (stat.count != '0 && report_enable) state_ff <= S_LIST;
               else if (last_ff || (stop_at_first && stat.count != '0 && stat.total_zero))
                  state_ff <= S_SUM;
               else state_ff <= S_IDLE;
            end
            S_LIST: state_ff <= S_LEN;
            S_LEN: state_ff <= S_EMIT;
            S_EMIT: if (!stat.out_busy) begin
               if (!stat.rep_done) state_ff <= S_LIST;
               else if (ended_ff) state_ff <= S_SUM;
               else state_ff <= S_IDLE;
            end
            S_SUM: if (!stat.out_busy) begin
               if (!last_ff) stop_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_emit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_rep && cmd.emit_sum)) else $error("report and summary together");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("accepted while busy");
   a_trans_info: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRANS) |=> (state_ff == S_INFO)) else $error("step sequence broken");
`endif

endmodule
